FILE: rtl/core/urm_pkg.sv
// ----------------------------------------------------------------------------
// UART register model package
// Request and response types, command codes, register offsets, bit positions
// and the receive level threshold table.
// ----------------------------------------------------------------------------
package urm_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] offset;
    logic [31:0] data;
  } urm_req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        data_valid;
    logic        irq_inject;
  } urm_rsp_t;

  typedef enum logic [2:0] {
    CMD_BUS_READ  = 3'd0,
    CMD_BUS_WRITE = 3'd1,
    CMD_RX_PUSH   = 3'd2,
    CMD_TX_PULL   = 3'd3,
    CMD_REFRESH   = 3'd4
  } urm_cmd_e;

  // Register byte offsets.
  localparam logic [11:0] OFF_DATA   = 12'h000;
  localparam logic [11:0] OFF_RSR    = 12'h004;
  localparam logic [11:0] OFF_FLAG   = 12'h018;
  localparam logic [11:0] OFF_ILPR   = 12'h020;
  localparam logic [11:0] OFF_IBRD   = 12'h024;
  localparam logic [11:0] OFF_FBRD   = 12'h028;
  localparam logic [11:0] OFF_LCR    = 12'h02c;
  localparam logic [11:0] OFF_CTRL   = 12'h030;
  localparam logic [11:0] OFF_LEVEL  = 12'h034;
  localparam logic [11:0] OFF_MASK   = 12'h038;
  localparam logic [11:0] OFF_RAW    = 12'h03c;
  localparam logic [11:0] OFF_MIS    = 12'h040;
  localparam logic [11:0] OFF_ICLR   = 12'h044;
  localparam logic [11:0] OFF_DMACR  = 12'h048;
  localparam logic [11:0] OFF_PID0   = 12'hfe0;
  localparam logic [11:0] OFF_PID1   = 12'hfe4;
  localparam logic [11:0] OFF_PID2   = 12'hfe8;
  localparam logic [11:0] OFF_PID3   = 12'hfec;
  localparam logic [11:0] OFF_CID0   = 12'hff0;
  localparam logic [11:0] OFF_CID1   = 12'hff4;
  localparam logic [11:0] OFF_CID2   = 12'hff8;
  localparam logic [11:0] OFF_CID3   = 12'hffc;

  // Identification words.
  localparam logic [31:0] ID_PID0 = 32'h11;
  localparam logic [31:0] ID_PID1 = 32'h10;
  localparam logic [31:0] ID_PID2 = 32'h14;
  localparam logic [31:0] ID_PID3 = 32'h00;
  localparam logic [31:0] ID_CID0 = 32'h0d;
  localparam logic [31:0] ID_CID1 = 32'hf0;
  localparam logic [31:0] ID_CID2 = 32'h05;
  localparam logic [31:0] ID_CID3 = 32'hb1;

  // Index of the plain storage registers.
  localparam int PL_RSR   = 0;
  localparam int PL_ILPR  = 1;
  localparam int PL_IBRD  = 2;
  localparam int PL_FBRD  = 3;
  localparam int PL_DMACR = 4;
  localparam int PL_NUM   = 5;

  // Flag register bits.
  localparam int FL_RXFE = 4;
  localparam int FL_TXFF = 5;
  localparam int FL_RXFF = 6;
  localparam int FL_TXFE = 7;

  // Interrupt bits.
  localparam int IR_RX = 4;
  localparam int IR_TX = 5;
  localparam int IR_RT = 6;

  // Control bits.
  localparam int CT_EN  = 0;
  localparam int CT_TXE = 8;
  localparam int CT_RXE = 9;

  localparam int FULL_MARGIN = 64;

  localparam logic [31:0] RST_FLAG  = 32'h90;
  localparam logic [31:0] RST_RAW   = 32'h20;
  localparam logic [31:0] RST_CTRL  = 32'h301;
  localparam logic [31:0] RST_LEVEL = 32'h12;
  localparam logic [31:0] RST_LCR   = 32'h70;

  localparam logic [3:0] LEVEL_THRESH [8] = '{
    4'd2, 4'd4, 4'd8, 4'd12, 4'd14, 4'd0, 4'd0, 4'd0
  };

endpackage

FILE: rtl/core/uart_register_model_with_fifos.sv
// ----------------------------------------------------------------------------
// UART register model with receive and transmit rings
// Register file of a UART with one receive and one transmit byte ring held in
// single-port-per-side synchronous memories.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle without gaps while the output does not
// stall: bus read, bus write, host receive push, host transmit pull or status
// refresh. All pointers, counts and status registers are updated at the edge
// that accepts the request, and the ring memory access for that request is
// issued at the same edge; the byte is registered at the memory output and
// the response is then held in an output register. Each request touches at
// most one entry of one ring, and every read of an entry follows the write of
// that entry at an earlier edge, so no forwarding is needed. The ring memories
// need no clearing after reset.
module uart_register_model_with_fifos
  import urm_pkg::*;
#(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 2048
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  urm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output urm_rsp_t out_rsp_o
);

  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  typedef struct packed {
    logic [7:4] flag;
    logic [6:4] raw;
  } stat_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        from_rx;
    logic        from_tx;
    logic        data_valid;
    logic        irq_inject;
  } stage_t;

  function automatic logic [RX_PW-1:0] rx_next(logic [RX_PW-1:0] p);
    return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_PW-1:0] tx_next(logic [TX_PW-1:0] p);
    return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic stat_t rx_status(logic [RX_CW-1:0] cnt, logic [2:0] code, stat_t s);
    stat_t r;
    r = s;
    r.raw[IR_RX]   = cnt >= RX_CW'(LEVEL_THRESH[code]);
    r.flag[FL_RXFF] = (RX_CW'(RX_DEPTH) - cnt) < RX_CW'(FULL_MARGIN);
    r.raw[IR_RT]   = cnt != '0;
    r.flag[FL_RXFE] = cnt == '0;
    return r;
  endfunction

  function automatic stat_t tx_status(stat_t s);
    stat_t r;
    r = s;
    r.raw[IR_TX]    = 1'b1;
    r.flag[FL_TXFF] = 1'b0;
    r.flag[FL_TXFE] = 1'b1;
    return r;
  endfunction

  // Ring memories.
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd_q, tx_rd_q;
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] wr_byte;

  // Ring control.
  logic [RX_PW-1:0] rx_rp_q, rx_rp_d, rx_wp_q, rx_wp_d;
  logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
  logic [TX_PW-1:0] tx_rp_q, tx_rp_d, tx_wp_q, tx_wp_d;
  logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;

  // Register file.
  stat_t       stat_q, stat_d;
  logic [6:4]  masked_q, masked_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] ctrl_q, ctrl_d;
  logic [31:0] level_q, level_d;
  logic [31:0] lcr_q, lcr_d;
  logic [31:0] plain_q [PL_NUM];
  logic [31:0] plain_d [PL_NUM];

  // Pipeline.
  logic     accept, out_ready;
  logic     s1_valid_q;
  stage_t   s1_q, s1_d;
  logic     out_valid_q;
  urm_rsp_t out_q;
  logic     post;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_byte    = in_req_i.data[7:0];

  always_comb begin
    rx_rp_d  = rx_rp_q;
    rx_wp_d  = rx_wp_q;
    rx_cnt_d = rx_cnt_q;
    tx_rp_d  = tx_rp_q;
    tx_wp_d  = tx_wp_q;
    tx_cnt_d = tx_cnt_q;
    stat_d   = stat_q;
    masked_d = masked_q;
    mask_d   = mask_q;
    ctrl_d   = ctrl_q;
    level_d  = level_q;
    lcr_d    = lcr_q;
    plain_d  = plain_q;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    post     = 1'b0;
    s1_d     = '0;

    if (accept) begin
      unique case (urm_cmd_e'(in_req_i.cmd))
        CMD_BUS_READ: begin
          unique case (in_req_i.offset)
            OFF_DATA: begin
              if (ctrl_q[CT_EN] && ctrl_q[CT_RXE] && rx_cnt_q != '0) begin
                rx_re           = 1'b1;
                rx_rp_d         = rx_next(rx_rp_q);
                rx_cnt_d        = rx_cnt_q - 1'b1;
                stat_d          = rx_status(rx_cnt_d, level_q[5:3], stat_q);
                s1_d.from_rx    = 1'b1;
                s1_d.data_valid = 1'b1;
              end
            end
            OFF_RSR:   s1_d.rdata = plain_q[PL_RSR];
            OFF_FLAG:  s1_d.rdata = {24'd0, stat_q.flag, 4'd0};
            OFF_ILPR:  s1_d.rdata = plain_q[PL_ILPR];
            OFF_IBRD:  s1_d.rdata = plain_q[PL_IBRD];
            OFF_FBRD:  s1_d.rdata = plain_q[PL_FBRD];
            OFF_LCR:   s1_d.rdata = lcr_q;
            OFF_CTRL:  s1_d.rdata = ctrl_q;
            OFF_LEVEL: s1_d.rdata = level_q;
            OFF_MASK:  s1_d.rdata = mask_q;
            OFF_RAW:   s1_d.rdata = {25'd0, stat_q.raw, 4'd0};
            OFF_MIS:   s1_d.rdata = {25'd0, masked_q, 4'd0};
            OFF_DMACR: s1_d.rdata = plain_q[PL_DMACR];
            OFF_PID0:  s1_d.rdata = ID_PID0;
            OFF_PID1:  s1_d.rdata = ID_PID1;
            OFF_PID2:  s1_d.rdata = ID_PID2;
            OFF_PID3:  s1_d.rdata = ID_PID3;
            OFF_CID0:  s1_d.rdata = ID_CID0;
            OFF_CID1:  s1_d.rdata = ID_CID1;
            OFF_CID2:  s1_d.rdata = ID_CID2;
            OFF_CID3:  s1_d.rdata = ID_CID3;
            default:   s1_d.rdata = '0;
          endcase
        end
        CMD_BUS_WRITE: begin
          unique case (in_req_i.offset)
            OFF_DATA: begin
              if (ctrl_q[CT_EN] && ctrl_q[CT_TXE]) begin
                tx_we   = 1'b1;
                tx_wp_d = tx_next(tx_wp_q);
                if (tx_cnt_q == TX_CW'(TX_DEPTH)) begin
                  tx_rp_d = tx_next(tx_rp_q);
                end else begin
                  tx_cnt_d = tx_cnt_q + 1'b1;
                end
                stat_d = tx_status(stat_q);
              end
            end
            OFF_RSR:   plain_d[PL_RSR]   = in_req_i.data;
            OFF_ILPR:  plain_d[PL_ILPR]  = in_req_i.data;
            OFF_IBRD:  plain_d[PL_IBRD]  = in_req_i.data;
            OFF_FBRD:  plain_d[PL_FBRD]  = in_req_i.data;
            OFF_DMACR: plain_d[PL_DMACR] = in_req_i.data;
            OFF_LCR: begin
              lcr_d  = in_req_i.data;
              stat_d = rx_status(rx_cnt_q, level_q[5:3], tx_status(stat_q));
              post   = 1'b1;
            end
            OFF_LEVEL: begin
              level_d = in_req_i.data;
              stat_d  = rx_status(rx_cnt_q, in_req_i.data[5:3], tx_status(stat_q));
              post    = 1'b1;
            end
            OFF_CTRL: begin
              ctrl_d = in_req_i.data;
              post   = 1'b1;
            end
            OFF_MASK: begin
              mask_d = in_req_i.data;
              post   = 1'b1;
            end
            OFF_ICLR: begin
              stat_d.raw = stat_q.raw & ~in_req_i.data[6:4];
              masked_d   = masked_q & ~in_req_i.data[6:4];
            end
            default: ;
          endcase
        end
        CMD_RX_PUSH: begin
          rx_we   = 1'b1;
          rx_wp_d = rx_next(rx_wp_q);
          if (rx_cnt_q == RX_CW'(RX_DEPTH)) begin
            rx_rp_d = rx_next(rx_rp_q);
          end else begin
            rx_cnt_d = rx_cnt_q + 1'b1;
          end
        end
        CMD_TX_PULL: begin
          if (tx_cnt_q != '0) begin
            tx_re           = 1'b1;
            tx_rp_d         = tx_next(tx_rp_q);
            tx_cnt_d        = tx_cnt_q - 1'b1;
            s1_d.from_tx    = 1'b1;
            s1_d.data_valid = 1'b1;
          end else begin
            s1_d.rdata = 32'hff;
          end
        end
        CMD_REFRESH: begin
          stat_d = rx_status(rx_cnt_q, level_q[5:3], tx_status(stat_q));
          post   = 1'b1;
        end
        default: ;
      endcase
    end

    // Interrupt post works on the values this request leaves behind.
    if (post) begin
      masked_d = mask_d[6:4] & stat_d.raw;
      s1_d.irq_inject = (masked_d != '0) && ctrl_d[CT_EN] &&
                        ((masked_d[IR_TX] && ctrl_d[CT_TXE]) ||
                         ((masked_d[IR_RX] || masked_d[IR_RT]) && ctrl_d[CT_RXE]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wp_q] <= wr_byte;
    end
    if (rx_re) begin
      rx_rd_q <= rx_mem[rx_rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_wp_q] <= wr_byte;
    end
    if (tx_re) begin
      tx_rd_q <= tx_mem[tx_rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_rp_q  <= '0;
      rx_wp_q  <= '0;
      rx_cnt_q <= '0;
      tx_rp_q  <= '0;
      tx_wp_q  <= '0;
      tx_cnt_q <= '0;
      stat_q   <= '{flag: RST_FLAG[7:4], raw: RST_RAW[6:4]};
      masked_q <= '0;
      mask_q   <= '0;
      ctrl_q   <= RST_CTRL;
      level_q  <= RST_LEVEL;
      lcr_q    <= RST_LCR;
      plain_q  <= '{default: '0};
    end else begin
      rx_rp_q  <= rx_rp_d;
      rx_wp_q  <= rx_wp_d;
      rx_cnt_q <= rx_cnt_d;
      tx_rp_q  <= tx_rp_d;
      tx_wp_q  <= tx_wp_d;
      tx_cnt_q <= tx_cnt_d;
      stat_q   <= stat_d;
      masked_q <= masked_d;
      mask_q   <= mask_d;
      ctrl_q   <= ctrl_d;
      level_q  <= level_d;
      lcr_q    <= lcr_d;
      plain_q  <= plain_d;
    end
  end

  // Valid bits of the memory stage and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_ready) begin
        s1_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // The ring byte is picked up here, once the memory has delivered it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (out_ready) begin
      if (s1_q.from_rx) begin
        out_q.rdata <= {24'd0, rx_rd_q};
      end else if (s1_q.from_tx) begin
        out_q.rdata <= {24'd0, tx_rd_q};
      end else begin
        out_q.rdata <= s1_q.rdata;
      end
      out_q.data_valid <= s1_q.data_valid;
      out_q.irq_inject <= s1_q.irq_inject;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_rx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q <= RX_CW'(RX_DEPTH))
    else $error("receive count above ring depth");

  a_rx_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_cnt_q == '0) |-> (rx_rp_q == rx_wp_q))
    else $error("empty receive ring with pointers apart");

  a_tx_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_cnt_q == '0) |-> (tx_rp_q == tx_wp_q))
    else $error("empty transmit ring with pointers apart");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("request stalled while the output side can move");

  a_valid_irq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.data_valid && out_rsp_o.irq_inject))
    else $error("ring byte and interrupt injection in one response");
`endif

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// UART register model testbench
// Sends bus reads and writes, host ring pushes and pulls and status refreshes
// through the request handshake with random gaps and output stalls. Each
// response is checked in order against an in-line model of the registers,
// the flags and the receive and transmit rings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urm_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RX_DEPTH       = 256;
  localparam int TX_DEPTH       = 2048;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int TAIL_LEN       = 60;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [11:0] WRITE_OFFS [13] = '{
    OFF_RSR, OFF_ILPR, OFF_IBRD, OFF_FBRD, OFF_LCR, OFF_CTRL, OFF_LEVEL,
    OFF_MASK, OFF_ICLR, OFF_DMACR, OFF_FLAG, OFF_RAW, OFF_MIS
  };

  localparam logic [11:0] READ_OFFS [22] = '{
    OFF_DATA, OFF_RSR, OFF_FLAG, OFF_ILPR, OFF_IBRD, OFF_FBRD, OFF_LCR,
    OFF_CTRL, OFF_LEVEL, OFF_MASK, OFF_RAW, OFF_MIS, OFF_ICLR, OFF_DMACR,
    OFF_PID0, OFF_PID1, OFF_PID2, OFF_PID3, OFF_CID0, OFF_CID1, OFF_CID2,
    OFF_CID3
  };

  typedef struct {
    urm_req_t req;
    bit       wait_drain;
  } queued_req_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  urm_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  urm_rsp_t out_rsp_o;

  queued_req_t pending_reqs [$];
  urm_rsp_t    expected_rsps [$];
  int          error_count = 0;

  // Modelled state of the block.
  logic [7:0]  rx_bytes [RX_DEPTH];
  logic [7:0]  rx_rd    = '0;
  logic [7:0]  rx_wr    = '0;
  logic [8:0]  rx_fill  = '0;
  logic [7:0]  tx_bytes [TX_DEPTH];
  logic [10:0] tx_rd    = '0;
  logic [10:0] tx_wr    = '0;
  logic [11:0] tx_fill  = '0;
  logic [31:0] flag_q   = RST_FLAG;
  logic [31:0] raw_q    = RST_RAW;
  logic [31:0] mis_q    = '0;
  logic [31:0] mask_q   = '0;
  logic [31:0] ctrl_q   = RST_CTRL;
  logic [31:0] level_q  = RST_LEVEL;
  logic [31:0] lcr_q    = RST_LCR;
  logic [31:0] plain_q [PL_NUM] = '{default: '0};

  // Idling control for both sides.
  int send_gap   = 0;
  int send_span  = 0;
  int send_pct   = 0;
  int stall_left = 0;
  int stall_span = 0;
  int stall_pct  = 0;

  uart_register_model_with_fifos u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void set_tx_status();
    raw_q[IR_TX]   = 1'b1;
    flag_q[FL_TXFF] = 1'b0;
    flag_q[FL_TXFE] = 1'b1;
  endfunction

  function automatic void set_rx_status();
    logic [3:0] thresh;
    thresh = LEVEL_THRESH[level_q[5:3]];
    raw_q[IR_RX]    = (rx_fill >= thresh);
    flag_q[FL_RXFF] = ((RX_DEPTH - int'(rx_fill)) < FULL_MARGIN);
    raw_q[IR_RT]    = (rx_fill != 0);
    flag_q[FL_RXFE] = (rx_fill == 0);
  endfunction

  function automatic bit post_interrupt();
    mis_q = mask_q & raw_q;
    return (mis_q != 0) && ctrl_q[CT_EN] &&
           ((mis_q[IR_TX] && ctrl_q[CT_TXE]) ||
            ((mis_q[IR_RX] || mis_q[IR_RT]) && ctrl_q[CT_RXE]));
  endfunction

  function automatic bit refresh_status();
    set_tx_status();
    set_rx_status();
    return post_interrupt();
  endfunction

  // Applies one request to the modelled state and returns its response.
  function automatic urm_rsp_t predict_response(urm_req_t r);
    urm_rsp_t rsp;
    rsp = '0;
    case (r.cmd)
      CMD_BUS_READ: begin
        case (r.offset)
          OFF_DATA: begin
            if (ctrl_q[CT_EN] && ctrl_q[CT_RXE] && rx_fill != 0) begin
              rsp.rdata      = {24'd0, rx_bytes[rx_rd]};
              rsp.data_valid = 1'b1;
              rx_rd++;
              rx_fill--;
              set_rx_status();
            end
          end
          OFF_RSR:   rsp.rdata = plain_q[PL_RSR];
          OFF_FLAG:  rsp.rdata = flag_q;
          OFF_ILPR:  rsp.rdata = plain_q[PL_ILPR];
          OFF_IBRD:  rsp.rdata = plain_q[PL_IBRD];
          OFF_FBRD:  rsp.rdata = plain_q[PL_FBRD];
          OFF_LCR:   rsp.rdata = lcr_q;
          OFF_CTRL:  rsp.rdata = ctrl_q;
          OFF_LEVEL: rsp.rdata = level_q;
          OFF_MASK:  rsp.rdata = mask_q;
          OFF_RAW:   rsp.rdata = raw_q;
          OFF_MIS:   rsp.rdata = mis_q;
          OFF_DMACR: rsp.rdata = plain_q[PL_DMACR];
          OFF_PID0:  rsp.rdata = ID_PID0;
          OFF_PID1:  rsp.rdata = ID_PID1;
          OFF_PID2:  rsp.rdata = ID_PID2;
          OFF_PID3:  rsp.rdata = ID_PID3;
          OFF_CID0:  rsp.rdata = ID_CID0;
          OFF_CID1:  rsp.rdata = ID_CID1;
          OFF_CID2:  rsp.rdata = ID_CID2;
          OFF_CID3:  rsp.rdata = ID_CID3;
          default:   rsp.rdata = '0;
        endcase
      end
      CMD_BUS_WRITE: begin
        case (r.offset)
          OFF_DATA: begin
            if (ctrl_q[CT_EN] && ctrl_q[CT_TXE]) begin
              // A full ring drops its oldest byte.
              tx_bytes[tx_wr] = r.data[7:0];
              if (tx_fill < TX_DEPTH) tx_fill++;
              else tx_rd++;
              tx_wr++;
              set_tx_status();
            end
          end
          OFF_RSR:   plain_q[PL_RSR] = r.data;
          OFF_ILPR:  plain_q[PL_ILPR] = r.data;
          OFF_IBRD:  plain_q[PL_IBRD] = r.data;
          OFF_FBRD:  plain_q[PL_FBRD] = r.data;
          OFF_DMACR: plain_q[PL_DMACR] = r.data;
          OFF_LCR: begin
            lcr_q = r.data;
            rsp.irq_inject = refresh_status();
          end
          OFF_LEVEL: begin
            level_q = r.data;
            rsp.irq_inject = refresh_status();
          end
          OFF_CTRL: begin
            ctrl_q = r.data;
            rsp.irq_inject = post_interrupt();
          end
          OFF_MASK: begin
            mask_q = r.data;
            rsp.irq_inject = post_interrupt();
          end
          OFF_ICLR: begin
            raw_q &= ~r.data;
            mis_q &= ~r.data;
          end
          default: ;
        endcase
      end
      CMD_RX_PUSH: begin
        rx_bytes[rx_wr] = r.data[7:0];
        if (rx_fill < RX_DEPTH) rx_fill++;
        else rx_rd++;
        rx_wr++;
      end
      CMD_TX_PULL: begin
        if (tx_fill != 0) begin
          rsp.rdata      = {24'd0, tx_bytes[tx_rd]};
          rsp.data_valid = 1'b1;
          tx_rd++;
          tx_fill--;
        end else begin
          rsp.rdata = 32'hff;
        end
      end
      CMD_REFRESH: rsp.irq_inject = refresh_status();
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic add_req(input logic [2:0] cmd, input logic [11:0] off,
                         input logic [31:0] dat, input bit drain = 1'b0);
    queued_req_t q;
    q.req.cmd    = cmd;
    q.req.offset = off;
    q.req.data   = dat;
    q.wait_drain = drain;
    pending_reqs.push_back(q);
  endtask

  // push_w and pop_w are percentages for receive pushes and data reads.
  task automatic add_random_req(input int push_w, input int pop_w);
    int          pick;
    logic [11:0] off;
    logic [31:0] dat;
    pick = $urandom_range(0, 99);
    dat  = $urandom;
    if (pick < push_w) begin
      add_req(CMD_RX_PUSH, 12'($urandom), dat);
    end else if (pick < push_w + pop_w) begin
      add_req(CMD_BUS_READ, OFF_DATA, dat);
    end else begin
      case ($urandom_range(0, 9))
        0, 1: add_req(CMD_BUS_WRITE, OFF_DATA, dat);
        2, 3: add_req(CMD_TX_PULL, 12'($urandom), dat);
        4:    add_req(CMD_REFRESH, 12'($urandom), dat);
        5, 6: begin
          off = WRITE_OFFS[$urandom_range(0, 12)];
          // Keep the block enabled most of the time so the rings stay busy.
          if (off == OFF_CTRL && $urandom_range(0, 3) != 0) begin
            dat[CT_EN]  = 1'b1;
            dat[CT_TXE] = 1'b1;
            dat[CT_RXE] = 1'b1;
          end
          add_req(CMD_BUS_WRITE, off, dat);
        end
        7, 8: add_req(CMD_BUS_READ, READ_OFFS[$urandom_range(0, 21)], dat);
        default: add_req(3'($urandom_range(0, 7)), 12'($urandom), dat);
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    queued_req_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(predict_response(in_req_i));
      end
      if (send_span == 0) begin
        send_span = 40;
        case ($urandom_range(0, 3))
          0, 1:    send_pct = 0;
          2:       send_pct = 15;
          default: send_pct = 40;
        endcase
      end else begin
        send_span--;
      end
      if (in_valid_i && in_stall_o) begin
        // The stalled request is held as it is.
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].wait_drain && expected_rsps.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() >= TAIL_LEN &&
                   $urandom_range(0, 99) < send_pct) begin
        send_gap = $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        in_req_i   <= next_req.req;
        in_valid_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    urm_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        note_error($sformatf("Unexpected response: rdata %08h valid %0b irq %0b",
                             out_rsp_o.rdata, out_rsp_o.data_valid,
                             out_rsp_o.irq_inject));
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp_o.rdata !== want.rdata)
          note_error($sformatf("rdata mismatch: expected %08h, got %08h",
                               want.rdata, out_rsp_o.rdata));
        if (out_rsp_o.data_valid !== want.data_valid)
          note_error($sformatf("data_valid mismatch: expected %0b, got %0b",
                               want.data_valid, out_rsp_o.data_valid));
        if (out_rsp_o.irq_inject !== want.irq_inject)
          note_error($sformatf("irq_inject mismatch: expected %0b, got %0b",
                               want.irq_inject, out_rsp_o.irq_inject));
      end
    end
    if (stall_span == 0) begin
      stall_span = 50;
      case ($urandom_range(0, 3))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 15;
        default: stall_pct = 40;
      endcase
    end else begin
      stall_span--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (pending_reqs.size() >= TAIL_LEN &&
                 $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    // Reset values, identification words and unmapped offsets.
    add_req(CMD_BUS_READ, OFF_FLAG, '0);
    add_req(CMD_BUS_READ, OFF_RAW, '0);
    add_req(CMD_BUS_READ, OFF_CTRL, '0);
    add_req(CMD_BUS_READ, OFF_CID3, '0);
    add_req(CMD_BUS_READ, OFF_ICLR, '0);
    add_req(CMD_BUS_READ, 12'hfff, 32'hffffffff);
    add_req(CMD_SPARE_7, 12'hfff, 32'hffffffff);
    add_req(CMD_SPARE_5, '0, '0);
    // Both rings empty.
    add_req(CMD_TX_PULL, '0, '0);
    add_req(CMD_BUS_READ, OFF_DATA, '0);
    add_req(CMD_RX_PUSH, '0, 32'hffffffff);
    add_req(CMD_RX_PUSH, '0, 32'h00000100);
    add_req(CMD_BUS_WRITE, OFF_MASK, 32'h70);
    // Threshold code 5 is reserved and gives a threshold of zero.
    add_req(CMD_BUS_WRITE, OFF_LEVEL, 32'h28);
    add_req(CMD_REFRESH, '0, '0);
    add_req(CMD_BUS_WRITE, OFF_DATA, 32'hdeadbea5);
    add_req(CMD_TX_PULL, '0, '0);
    add_req(CMD_BUS_READ, OFF_DATA, '0);
    add_req(CMD_BUS_WRITE, OFF_ICLR, 32'hffffffff);
    // With the block disabled a data read pops nothing and a data write is dropped.
    add_req(CMD_BUS_WRITE, OFF_CTRL, '0);
    add_req(CMD_BUS_READ, OFF_DATA, '0);
    add_req(CMD_BUS_WRITE, OFF_DATA, 32'h12345678);
    add_req(CMD_BUS_WRITE, OFF_CTRL, RST_CTRL);
    add_req(CMD_BUS_WRITE, OFF_FLAG, 32'hffffffff);
    add_req(CMD_BUS_WRITE, OFF_DMACR, 32'hffffffff);

    for (int i = 0; i < 120; i++) add_random_req(20, 15);
    // Fill the receive ring past its margin and into overwrite.
    add_req(CMD_REFRESH, '0, '0, 1'b1);
    for (int i = 0; i < 300; i++) add_random_req(95, 1);
    add_req(CMD_REFRESH, '0, '0, 1'b1);
    for (int i = 0; i < 105; i++) add_random_req(10, 40);

    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout: %0d responses still outstanding", expected_rsps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
